// ===== hw/rtl/pba_pkg.sv =====
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and constants for the page bitmap first-fit allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int NUM_PAGES  = 128;
  localparam int PAGE_BYTES = 4096;   // power of two

  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 20;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PG_CNT_W   = SIZE_W - PAGE_SHIFT;
  localparam int RUN_W      = $clog2(NUM_PAGES + 1);
  localparam int CNT_W      = (PG_CNT_W > RUN_W) ? PG_CNT_W : RUN_W;

  localparam int WORD_BITS  = 8;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int ROWS       = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PG_W       = ROW_W + BIT_W;
  localparam int EXT_W      = ((PG_W > CNT_W) ? PG_W : CNT_W) + 1;

  localparam logic [ADDR_W:0] POOL_SPAN = (ADDR_W + 1)'(NUM_PAGES * PAGE_BYTES);

  localparam int CFG_ADDR_W = 3;
  localparam logic [SIZE_W-1:0] MIN_SIZE_RST = SIZE_W'(4096);

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } pba_op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_INVALID  = 2'd1,
    STAT_NO_SPACE = 2'd2,
    STAT_IGNORED  = 2'd3
  } pba_status_t;

  typedef enum logic [0:0] {
    REG_POOL_BASE = 1'b0,
    REG_MIN_SIZE  = 1'b1
  } pba_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FREE_RANGE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_MARK_RD,
    S_MARK_WR,
    S_DONE
  } pba_state_t;

  typedef struct packed {
    pba_op_t             opcode;
    logic [SIZE_W-1:0]   size_bytes;
    logic [ADDR_W-1:0]   address;
  } pba_in_t;

  typedef struct packed {
    pba_status_t         status;
    logic [ADDR_W-1:0]   base_address;
    logic [SIZE_W-1:0]   granted_size;
  } pba_out_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   pool_base;
    logic [SIZE_W-1:0]   min_size;
  } pba_cfg_t;

  typedef struct packed {
    logic                 rd_en;
    logic [ROW_W-1:0]     rd_row;
    logic                 wr_en;
    logic [ROW_W-1:0]     wr_row;
    logic [WORD_BITS-1:0] wr_data;
  } pba_mem_req_t;

endpackage

// ===== hw/rtl/pba_regs.sv =====
// ----------------------------------------------------------------------------
// pba_regs
// APB-style configuration registers: pool base address and minimum size.
// ----------------------------------------------------------------------------
module pba_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pba_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output pba_pkg::pba_cfg_t              cfg
);

  logic [pba_pkg::ADDR_W-1:0] pool_base_r;
  logic [pba_pkg::SIZE_W-1:0] min_size_r;
  logic                       wr_stb;
  pba_pkg::pba_reg_t          reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = pba_pkg::pba_reg_t'(paddr[2]);
  assign wr_stb  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r <= '0;
      min_size_r  <= pba_pkg::MIN_SIZE_RST;
    end else if (wr_stb) begin
      unique case (reg_sel)
        pba_pkg::REG_POOL_BASE: pool_base_r <= pwdata;
        pba_pkg::REG_MIN_SIZE:  min_size_r  <= pwdata[pba_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      pba_pkg::REG_POOL_BASE: prdata = pool_base_r;
      pba_pkg::REG_MIN_SIZE:  prdata = {{(32 - pba_pkg::SIZE_W){1'b0}}, min_size_r};
      default:                prdata = '0;
    endcase
  end

  assign cfg.pool_base = pool_base_r;
  assign cfg.min_size  = min_size_r;

endmodule

// ===== hw/rtl/pba_bitmap_ram.sv =====
// ----------------------------------------------------------------------------
// pba_bitmap_ram
// Page-used bitmap, one row of WORD_BITS pages per entry. Registered read.
// Per-row valid bits make unwritten rows read as all free after reset.
// ----------------------------------------------------------------------------
module pba_bitmap_ram (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pba_pkg::pba_mem_req_t             req,
  output logic [pba_pkg::WORD_BITS-1:0]     rd_data
);

  logic [pba_pkg::WORD_BITS-1:0] mem [pba_pkg::ROWS];
  logic [pba_pkg::ROWS-1:0]      row_vld_r;
  logic [pba_pkg::WORD_BITS-1:0] rd_data_r;
  logic                          rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_row] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_vld_r[req.wr_row] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= row_vld_r[req.rd_row];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

  a_no_rw_same_row: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.rd_en && req.wr_en && (req.rd_row == req.wr_row)))
    else $error("bitmap read and write to same row in one cycle");

endmodule

// ===== hw/rtl/pba_engine.sv =====
// ----------------------------------------------------------------------------
// pba_engine
// Request check, first-fit scan and run mark/clear sequencer with the
// result register.
// ----------------------------------------------------------------------------
module pba_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pba_pkg::pba_cfg_t             cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pba_pkg::pba_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pba_pkg::pba_out_t             out_data,
  output pba_pkg::pba_mem_req_t         mem_req,
  input  logic [pba_pkg::WORD_BITS-1:0] mem_rdata
);

  localparam logic [pba_pkg::ROW_W-1:0] LAST_ROW = pba_pkg::ROW_W'(pba_pkg::ROWS - 1);
  localparam logic [pba_pkg::PG_W:0]    NPG_X    = (pba_pkg::PG_W + 1)'(pba_pkg::NUM_PAGES);
  localparam logic [pba_pkg::CNT_W-1:0] NPG_C    = pba_pkg::CNT_W'(pba_pkg::NUM_PAGES);
  localparam logic [pba_pkg::EXT_W-1:0] NPG_E    = pba_pkg::EXT_W'(pba_pkg::NUM_PAGES);

  pba_pkg::pba_state_t            state_r, state_nxt;
  pba_pkg::pba_in_t               item_r;
  pba_pkg::pba_status_t           status_r;
  logic [pba_pkg::CNT_W-1:0]      cnt_r;
  logic [pba_pkg::PG_W-1:0]       lo_r, hi_r, start_r;
  logic [pba_pkg::ROW_W-1:0]      row_r;
  logic [pba_pkg::RUN_W-1:0]      run_r;
  logic                           out_valid_r;
  pba_pkg::pba_out_t              out_data_r;

  logic                           in_fire, out_load;
  logic                           alloc_bad, alloc_nospace, free_bad;
  logic [pba_pkg::ADDR_W-1:0]     offset;
  logic [pba_pkg::CNT_W-1:0]      req_pages;
  logic [pba_pkg::EXT_W-1:0]      end_excl;
  logic [pba_pkg::PG_W-1:0]       hi_clip;
  logic                           last_mark_row;

  logic [pba_pkg::RUN_W-1:0]      run_v;
  logic [pba_pkg::PG_W-1:0]       start_v, fidx_v, idx_v;
  logic                           found_v;
  logic [pba_pkg::WORD_BITS-1:0]  wr_word;

  assign in_fire  = in_valid && in_ready;
  assign out_load = (state_r == pba_pkg::S_DONE) && (!out_valid_r || out_ready);

  // request checks
  assign offset    = item_r.address - cfg.pool_base;
  assign req_pages = pba_pkg::CNT_W'(item_r.size_bytes[pba_pkg::SIZE_W-1:pba_pkg::PAGE_SHIFT]);
  assign alloc_bad = (item_r.size_bytes < cfg.min_size) ||
                     (item_r.size_bytes[pba_pkg::PAGE_SHIFT-1:0] != '0);
  assign alloc_nospace = (req_pages == '0) || (req_pages > NPG_C);
  assign free_bad  = (item_r.address == '0) || (item_r.size_bytes == '0) ||
                     (item_r.address < cfg.pool_base) ||
                     ({1'b0, item_r.address} >= ({1'b0, cfg.pool_base} + pba_pkg::POOL_SPAN)) ||
                     (offset[pba_pkg::PAGE_SHIFT-1:0] != '0) ||
                     (item_r.size_bytes[pba_pkg::PAGE_SHIFT-1:0] != '0);

  assign end_excl = pba_pkg::EXT_W'(lo_r) + pba_pkg::EXT_W'(cnt_r);
  assign hi_clip  = (end_excl > NPG_E) ? pba_pkg::PG_W'(pba_pkg::NUM_PAGES - 1)
                                       : pba_pkg::PG_W'(end_excl - pba_pkg::EXT_W'(1));
  assign last_mark_row = (row_r == hi_r[pba_pkg::PG_W-1:pba_pkg::BIT_W]);

  // one row of the first-fit scan
  always_comb begin
    run_v   = run_r;
    start_v = start_r;
    found_v = 1'b0;
    fidx_v  = '0;
    idx_v   = '0;
    for (int b = 0; b < pba_pkg::WORD_BITS; b++) begin
      idx_v = {row_r, pba_pkg::BIT_W'(b)};
      if (!found_v) begin
        if (mem_rdata[b] || ({1'b0, idx_v} >= NPG_X)) begin
          run_v = '0;
        end else begin
          if (run_v == '0) begin
            start_v = idx_v;
          end
          run_v = run_v + pba_pkg::RUN_W'(1);
          if (pba_pkg::CNT_W'(run_v) == cnt_r) begin
            found_v = 1'b1;
            fidx_v  = idx_v;
          end
        end
      end
    end
  end

  // row rewrite for mark / clear
  always_comb begin
    wr_word = mem_rdata;
    for (int b = 0; b < pba_pkg::WORD_BITS; b++) begin
      if (({row_r, pba_pkg::BIT_W'(b)} >= lo_r) && ({row_r, pba_pkg::BIT_W'(b)} <= hi_r)) begin
        wr_word[b] = (item_r.opcode == pba_pkg::OP_ALLOC);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pba_pkg::S_IDLE:       if (in_valid) state_nxt = pba_pkg::S_CHECK;
      pba_pkg::S_CHECK: begin
        if (item_r.opcode == pba_pkg::OP_ALLOC) begin
          state_nxt = (alloc_bad || alloc_nospace) ? pba_pkg::S_DONE : pba_pkg::S_SCAN_RD;
        end else begin
          state_nxt = free_bad ? pba_pkg::S_DONE : pba_pkg::S_FREE_RANGE;
        end
      end
      pba_pkg::S_FREE_RANGE: state_nxt = pba_pkg::S_MARK_RD;
      pba_pkg::S_SCAN_RD:    state_nxt = pba_pkg::S_SCAN_EV;
      pba_pkg::S_SCAN_EV: begin
        priority if (found_v)             state_nxt = pba_pkg::S_MARK_RD;
        else if (row_r == LAST_ROW)       state_nxt = pba_pkg::S_DONE;
        else                              state_nxt = pba_pkg::S_SCAN_RD;
      end
      pba_pkg::S_MARK_RD:    state_nxt = pba_pkg::S_MARK_WR;
      pba_pkg::S_MARK_WR:    state_nxt = last_mark_row ? pba_pkg::S_DONE : pba_pkg::S_MARK_RD;
      pba_pkg::S_DONE:       if (out_load) state_nxt = pba_pkg::S_IDLE;
      default:               state_nxt = pba_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready        = 1'b0;
    mem_req.rd_en   = 1'b0;
    mem_req.rd_row  = row_r;
    mem_req.wr_en   = 1'b0;
    mem_req.wr_row  = row_r;
    mem_req.wr_data = wr_word;
    unique case (state_r)
      pba_pkg::S_IDLE:    in_ready      = 1'b1;
      pba_pkg::S_SCAN_RD: mem_req.rd_en = 1'b1;
      pba_pkg::S_MARK_RD: mem_req.rd_en = 1'b1;
      pba_pkg::S_MARK_WR: mem_req.wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pba_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r  <= in_data;
      run_r   <= '0;
      start_r <= '0;
      row_r   <= '0;
    end
    unique case (state_r)
      pba_pkg::S_CHECK: begin
        cnt_r <= req_pages;
        lo_r  <= offset[pba_pkg::PAGE_SHIFT +: pba_pkg::PG_W];
        if (item_r.opcode == pba_pkg::OP_ALLOC) begin
          status_r <= alloc_bad ? pba_pkg::STAT_INVALID :
                      alloc_nospace ? pba_pkg::STAT_NO_SPACE : pba_pkg::STAT_OK;
        end else begin
          status_r <= free_bad ? pba_pkg::STAT_IGNORED : pba_pkg::STAT_OK;
        end
      end
      pba_pkg::S_FREE_RANGE: begin
        hi_r  <= hi_clip;
        row_r <= lo_r[pba_pkg::PG_W-1:pba_pkg::BIT_W];
      end
      pba_pkg::S_SCAN_EV: begin
        run_r   <= run_v;
        start_r <= start_v;
        if (found_v) begin
          lo_r  <= start_v;
          hi_r  <= fidx_v;
          row_r <= start_v[pba_pkg::PG_W-1:pba_pkg::BIT_W];
        end else if (row_r == LAST_ROW) begin
          status_r <= pba_pkg::STAT_NO_SPACE;
        end else begin
          row_r <= row_r + pba_pkg::ROW_W'(1);
        end
      end
      pba_pkg::S_MARK_WR: begin
        if (!last_mark_row) begin
          row_r <= row_r + pba_pkg::ROW_W'(1);
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_r.status <= status_r;
      if ((status_r == pba_pkg::STAT_OK) && (item_r.opcode == pba_pkg::OP_ALLOC)) begin
        out_data_r.base_address <= cfg.pool_base +
                                   (pba_pkg::ADDR_W'(lo_r) << pba_pkg::PAGE_SHIFT);
        out_data_r.granted_size <= item_r.size_bytes;
      end else begin
        out_data_r.base_address <= '0;
        out_data_r.granted_size <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pba_pkg::S_MARK_WR) |-> ((lo_r <= hi_r) && ({1'b0, hi_r} < NPG_X)))
    else $error("mark range out of order or past pool end");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != pba_pkg::STAT_OK)) |->
      ((out_data_r.base_address == '0) && (out_data_r.granted_size == '0)))
    else $error("failed transaction carries nonzero address or size");

  a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == pba_pkg::S_SCAN_EV) && !found_v && (row_r != LAST_ROW)) |=>
      ((state_r == pba_pkg::S_SCAN_RD) && (row_r == $past(row_r) + pba_pkg::ROW_W'(1))))
    else $error("scan skipped or repeated a row");

endmodule

// ===== hw/rtl/page_bitmap_first_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// page_bitmap_first_fit_allocator
// First-fit page allocator over a used-bit bitmap held in a RAM with one read and one write port.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; a finished result sits in the output
// register while the next transaction is taken. The bitmap RAM holds 8 pages
// per row and has a registered read, so each row is read and then evaluated or
// rewritten. An allocate is checked, then scans rows (up to 16 for 128 pages)
// until the first fitting run is found, marks each row of that run, and posts
// the result. A free is checked, has its page range computed, and clears each
// row of it; a rejected transaction is checked and its result posted. Rows
// carry valid flags cleared by reset, so the pool is all free right out of
// reset with no clearing pass.
// ----------------------------------------------------------------------------
module page_bitmap_first_fit_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pba_pkg::pba_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pba_pkg::pba_out_t              out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pba_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  pba_pkg::pba_cfg_t             cfg;
  pba_pkg::pba_mem_req_t         mem_req;
  logic [pba_pkg::WORD_BITS-1:0] mem_rdata;

  pba_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pba_bitmap_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (mem_rdata)
  );

  pba_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

endmodule
